// ===== rtl/core/pbaq_pkg.sv =====
// shared types, constants and a helper function for the ascii block quantizer
`default_nettype none

package pbaq_pkg;

  // register map, selected by paddr[2]
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_GLYPH_TABLE = 1'b1;

  localparam logic [10:0] IMAGE_WIDTH_RST = 11'd1024;
  localparam logic [31:0] GLYPH_TABLE_RST = 32'h234F_2E20;

  localparam int unsigned QUEUE_DEPTH = 4;

  // (b+g+r)/3 >> 6 equals (b+g+r)/192, so the level is three threshold compares
  localparam int unsigned LEVEL_STEP = (256 / 4) * 3;

  typedef struct packed {
    logic first;    // first pixel row of the tile row, partial sum starts at zero
    logic last;     // last pixel row, tile completes
    logic row_end;  // last whole tile of the tile row
  } tile_flags_t;

  function automatic logic [1:0] pixel_level(input logic [7:0] b, input logic [7:0] g,
                                             input logic [7:0] r);
    logic [9:0] s;
    logic [1:0] lvl;
    s = 10'(b) + 10'(g) + 10'(r);
    if (s >= 10'(3 * LEVEL_STEP)) lvl = 2'd3;
    else if (s >= 10'(2 * LEVEL_STEP)) lvl = 2'd2;
    else if (s >= 10'(LEVEL_STEP)) lvl = 2'd1;
    else lvl = 2'd0;
    return lvl;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pixel_block_ascii_quantizer.sv =====
// top level: apb registers, pixel front end, command queue, tile back end
`default_nettype none

// Turns a raster stream of RGB pixels into one character code per whole
// BLOCK_SIZE x BLOCK_SIZE tile: grey = (b+g+r)/3 is cut to four levels, the
// levels of a tile are averaged and the average picks a byte of glyph_table.
// tlast marks the last whole tile of each tile row; partial tiles at the right
// and bottom edges give nothing, and tuser on a pixel restarts the frame.
// The block takes one pixel every clock cycle unless the command queue is full; a
// tile result passes through the queue and the s2 registers into the output register.
// The pixel rate is set by the partial-sum ram, which does one read and one write
// per cycle, with a four-entry command queue between the pixel counters and the ram
// side so that a stalled output does not stop the input at once. The partial-sum ram needs
// no clearing after reset: the first pixel row of each tile row overwrites it.
// Program image_width and glyph_table only while no pixel is in flight.
module pixel_block_ascii_quantizer #(
  parameter int unsigned BLOCK_SIZE = 3,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // pixels in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  wire logic        s_axis_tuser,   // frame_start
  // tiles out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // glyph [7:0], tile_column [16:8],
                                           // tile_row [25:17], zero [31:26]
  output logic             m_axis_tlast    // row_end
);

  localparam int unsigned TW    = $clog2(MAX_WIDTH / BLOCK_SIZE + 1);
  localparam int unsigned RW    = $clog2(3 * BLOCK_SIZE + 1);
  localparam int unsigned FW    = $bits(pbaq_pkg::tile_flags_t);
  localparam int unsigned CMD_W = FW + 9 + RW + TW;

  logic [10:0] image_width_q;
  logic [31:0] glyph_table_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= pbaq_pkg::IMAGE_WIDTH_RST;
      glyph_table_q <= pbaq_pkg::GLYPH_TABLE_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        pbaq_pkg::REG_IMAGE_WIDTH: image_width_q <= pwdata[10:0];
        pbaq_pkg::REG_GLYPH_TABLE: glyph_table_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pbaq_pkg::REG_IMAGE_WIDTH: prdata = {21'b0, image_width_q};
      pbaq_pkg::REG_GLYPH_TABLE: prdata = glyph_table_q;
      default:                   prdata = '0;
    endcase
  end

  logic                  push, pop, q_full, q_empty;
  logic [TW-1:0]         f_tcol, b_tcol;
  logic [RW-1:0]         f_run, b_run;
  logic [8:0]            f_trow, b_trow;
  pbaq_pkg::tile_flags_t f_flags, b_flags;
  logic [CMD_W-1:0]      q_out;
  logic [25:0]           m_payload;

  pbaq_front #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .image_width_i   (image_width_q),
    .s_valid_i       (s_axis_tvalid),
    .s_ready_o       (s_axis_tready),
    .s_data_i        (s_axis_tdata),
    .s_frame_start_i (s_axis_tuser),
    .q_full_i        (q_full),
    .push_o          (push),
    .tcol_o          (f_tcol),
    .run_o           (f_run),
    .trow_o          (f_trow),
    .flags_o         (f_flags)
  );

  pbaq_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_flags, f_trow, f_run, f_tcol}),
    .pop_i   (pop),
    .data_o  (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {b_flags, b_trow, b_run, b_tcol} = q_out;

  pbaq_back #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .glyph_table_i (glyph_table_q),
    .cmd_valid_i   (!q_empty),
    .pop_o         (pop),
    .cmd_tcol_i    (b_tcol),
    .cmd_run_i     (b_run),
    .cmd_trow_i    (b_trow),
    .cmd_flags_i   (b_flags),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_o      (m_payload),
    .m_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, m_payload};

endmodule

`default_nettype wire

// ===== rtl/core/pbaq_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module pbaq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/pbaq_queue.sv =====
// small register fifo carrying tile commands from front to back
`default_nettype none

module pbaq_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned DEPTH = pbaq_pkg::QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign full_o  = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("tile command queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("tile command queue underflow");

  a_count_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o)
    else $error("queue empty right after a push");

endmodule

`default_nettype wire

// ===== rtl/core/pbaq_front.sv =====
// pixel intake: position counters, grey level, per-row run sum, tile command issue
`default_nettype none

module pbaq_front #(
  parameter int unsigned BLOCK_SIZE = 3,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [10:0]           image_width_i,
  input  wire logic                  s_valid_i,
  output logic                       s_ready_o,
  input  wire logic [23:0]           s_data_i,
  input  wire logic                  s_frame_start_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output logic [$clog2(MAX_WIDTH / BLOCK_SIZE + 1)-1:0] tcol_o,
  output logic [$clog2(3 * BLOCK_SIZE + 1)-1:0]         run_o,
  output logic [8:0]                 trow_o,
  output pbaq_pkg::tile_flags_t      flags_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 2 * BLOCK_SIZE);
  localparam int unsigned XW = (CW > 11) ? CW : 11;
  localparam int unsigned TW = $clog2(MAX_WIDTH / BLOCK_SIZE + 1);
  localparam int unsigned SW = $clog2(BLOCK_SIZE);
  localparam int unsigned RW = $clog2(3 * BLOCK_SIZE + 1);

  logic [CW-1:0] col_q, col_d, tend_q, tend_d;
  logic [SW-1:0] sub_q, sub_d, phase_q, phase_d;
  logic [TW-1:0] tcol_q, tcol_d;
  logic [8:0]    trow_q, trow_d;
  logic [RW-1:0] run_q, run_d;

  logic [XW-1:0] width_x, ew_x;
  logic [CW-1:0] ew, c_col, c_tend, col_next;
  logic [SW-1:0] c_sub, c_phase;
  logic [TW-1:0] c_tcol;
  logic [8:0]    c_trow;
  logic [RW-1:0] c_run, run_new;
  logic [1:0]    level;
  logic          accept, in_tile, sub_last, phase_last;

  assign width_x = XW'(image_width_i);
  assign ew_x    = (width_x == '0) ? XW'(1) :
                   (width_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : width_x;
  assign ew      = CW'(ew_x);

  assign s_ready_o = !q_full_i;
  assign accept    = s_valid_i && s_ready_o;

  // frame start clears the counters before this pixel counts
  assign c_col   = s_frame_start_i ? '0 : col_q;
  assign c_tend  = s_frame_start_i ? CW'(BLOCK_SIZE) : tend_q;
  assign c_sub   = s_frame_start_i ? '0 : sub_q;
  assign c_phase = s_frame_start_i ? '0 : phase_q;
  assign c_tcol  = s_frame_start_i ? '0 : tcol_q;
  assign c_trow  = s_frame_start_i ? '0 : trow_q;
  assign c_run   = s_frame_start_i ? '0 : run_q;

  assign level      = pbaq_pkg::pixel_level(s_data_i[7:0], s_data_i[15:8], s_data_i[23:16]);
  assign in_tile    = (c_tend <= ew);
  assign sub_last   = (c_sub == SW'(BLOCK_SIZE - 1));
  assign phase_last = (c_phase == SW'(BLOCK_SIZE - 1));
  assign run_new    = ((c_sub == '0) ? '0 : c_run) + RW'(level);
  assign col_next   = c_col + 1'b1;

  always_comb begin
    col_d   = c_col;
    tend_d  = c_tend;
    sub_d   = c_sub;
    phase_d = c_phase;
    tcol_d  = c_tcol;
    trow_d  = c_trow;
    run_d   = in_tile ? run_new : c_run;
    if (col_next >= ew) begin
      col_d  = '0;
      tend_d = CW'(BLOCK_SIZE);
      sub_d  = '0;
      tcol_d = '0;
      if (phase_last) begin
        phase_d = '0;
        trow_d  = c_trow + 1'b1;
      end else begin
        phase_d = c_phase + 1'b1;
      end
    end else begin
      col_d = col_next;
      if (sub_last) begin
        sub_d  = '0;
        tcol_d = c_tcol + 1'b1;
        tend_d = c_tend + CW'(BLOCK_SIZE);
      end else begin
        sub_d = c_sub + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      tend_q  <= CW'(BLOCK_SIZE);
      sub_q   <= '0;
      phase_q <= '0;
      tcol_q  <= '0;
      trow_q  <= '0;
      run_q   <= '0;
    end else if (accept) begin
      col_q   <= col_d;
      tend_q  <= tend_d;
      sub_q   <= sub_d;
      phase_q <= phase_d;
      tcol_q  <= tcol_d;
      trow_q  <= trow_d;
      run_q   <= run_d;
    end
  end

  assign push_o          = accept && in_tile && sub_last;
  assign tcol_o          = c_tcol;
  assign run_o           = run_new;
  assign trow_o          = c_trow;
  assign flags_o.first   = (c_phase == '0);
  assign flags_o.last    = phase_last;
  assign flags_o.row_end = (c_tend + CW'(BLOCK_SIZE) > ew);

endmodule

`default_nettype wire

// ===== rtl/core/pbaq_back.sv =====
// tile completion: partial-sum ram update, tile average, glyph lookup, output register
`default_nettype none

module pbaq_back #(
  parameter int unsigned BLOCK_SIZE = 3,
  parameter int unsigned MAX_WIDTH  = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [31:0]           glyph_table_i,
  input  wire logic                  cmd_valid_i,
  output logic                       pop_o,
  input  wire logic [$clog2(MAX_WIDTH / BLOCK_SIZE + 1)-1:0] cmd_tcol_i,
  input  wire logic [$clog2(3 * BLOCK_SIZE + 1)-1:0]         cmd_run_i,
  input  wire logic [8:0]            cmd_trow_i,
  input  wire pbaq_pkg::tile_flags_t cmd_flags_i,
  output logic                       m_valid_o,
  input  wire logic                  m_ready_i,
  output logic [25:0]                m_data_o,
  output logic                       m_last_o
);

  localparam int unsigned SLOTS = MAX_WIDTH / BLOCK_SIZE + 1;
  localparam int unsigned TW    = $clog2(SLOTS);
  localparam int unsigned RW    = $clog2(3 * BLOCK_SIZE + 1);
  localparam int unsigned BB    = BLOCK_SIZE * BLOCK_SIZE;
  localparam int unsigned SUMW  = $clog2(3 * BB + 1);

  logic                  s2_valid_q, s2_valid_d;
  logic [TW-1:0]         s2_tcol_q;
  logic [RW-1:0]         s2_run_q;
  logic [8:0]            s2_trow_q;
  pbaq_pkg::tile_flags_t s2_flags_q;
  logic                  s2_fwd_q;
  logic [SUMW-1:0]       s2_fwd_data_q;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_glyph_q;
  logic [8:0]            out_tcol_q, out_trow_q;
  logic                  out_row_end_q;

  logic [SUMW-1:0] rd_data, prev_sum, total;
  logic            wr_en, s2_go, emit;
  logic [1:0]      q;

  pbaq_ram #(
    .WIDTH (SUMW),
    .DEPTH (SLOTS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s2_tcol_q),
    .wdata_i (total),
    .re_i    (pop_o),
    .raddr_i (cmd_tcol_i),
    .rdata_o (rd_data)
  );

  // a write to the address being read in the same cycle is forwarded
  assign prev_sum = s2_flags_q.first ? '0 : (s2_fwd_q ? s2_fwd_data_q : rd_data);
  assign total    = prev_sum + SUMW'(s2_run_q);
  assign wr_en    = s2_valid_q && !s2_flags_q.last;
  assign emit     = s2_valid_q && s2_flags_q.last;
  assign s2_go    = !emit || !out_valid_q || m_ready_i;
  assign pop_o    = cmd_valid_i && s2_go;

  always_comb begin
    if (total >= SUMW'(3 * BB)) q = 2'd3;
    else if (total >= SUMW'(2 * BB)) q = 2'd2;
    else if (total >= SUMW'(BB)) q = 2'd1;
    else q = 2'd0;
  end

  assign s2_valid_d  = s2_go ? pop_o : s2_valid_q;
  assign out_valid_d = (emit && s2_go) || (out_valid_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_tcol_q     <= cmd_tcol_i;
      s2_run_q      <= cmd_run_i;
      s2_trow_q     <= cmd_trow_i;
      s2_flags_q    <= cmd_flags_i;
      s2_fwd_q      <= wr_en && (s2_tcol_q == cmd_tcol_i);
      s2_fwd_data_q <= total;
    end
    if (emit && s2_go) begin
      out_glyph_q   <= glyph_table_i[8 * q +: 8];
      out_tcol_q    <= 9'(s2_tcol_q);
      out_trow_q    <= s2_trow_q;
      out_row_end_q <= s2_flags_q.row_end;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {out_trow_q, out_tcol_q, out_glyph_q};
  assign m_last_o  = out_row_end_q;

endmodule

`default_nettype wire

// ===== sim/pixel_block_ascii_quantizer_test.sv =====
// testbench for the ascii block quantizer: tile glyph prediction, stalls, register checks
module pixel_block_ascii_quantizer_test;

  localparam int unsigned BLOCK = 3;
  localparam int unsigned MAX_COLS = 1024;
  localparam int unsigned TILE_SLOTS = MAX_COLS / BLOCK + 1;
  localparam int DRAIN_CYCLES = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 50;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0] glyph;
    logic [8:0] tile_column;
    logic [8:0] tile_row;
    logic       row_end;
  } tile_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // blue [7:0], green [15:8], red [23:16]
  logic        s_axis_tuser = 1'b0; // frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // glyph [7:0], tile_column [16:8], tile_row [25:17]
  logic        m_axis_tlast;        // row_end

  pixel_block_ascii_quantizer #(
    .BLOCK_SIZE(BLOCK),
    .MAX_WIDTH (MAX_COLS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // predictor state and register copies
  logic [10:0] width_reg = pbaq_pkg::IMAGE_WIDTH_RST;
  logic [31:0] glyph_reg = pbaq_pkg::GLYPH_TABLE_RST;
  logic [10:0] col_pos = '0;
  logic [1:0]  row_phase = '0;
  logic [8:0]  tile_row_idx = '0;
  logic [3:0]  run_sum = '0;
  logic [4:0]  partial_sums [TILE_SLOTS];

  tile_t tiles_due [$];
  int    mismatch_count = 0;
  int    tiles_seen = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_cycles = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("tile %0d %s: got %0h, expected %0h", tiles_seen, what, got, want);
    mismatch_count++;
  endtask

  // one pixel through the predictor, pushing the finished tile if any
  task automatic quantize_pixel(input pixel_t px);
    int unsigned eff_w, tiles, tcol, sub, grey, total, avg;
    logic [1:0] lvl;
    tile_t t;
    if (px.frame_start) begin
      col_pos = '0;
      row_phase = '0;
      tile_row_idx = '0;
      run_sum = '0;
    end
    eff_w = (width_reg == 0) ? 1 : ((width_reg > MAX_COLS) ? MAX_COLS : width_reg);
    tiles = eff_w / BLOCK;
    grey = (32'(px.blue) + 32'(px.green) + 32'(px.red)) / 3;
    lvl = 2'((grey * 4) / 256);
    tcol = col_pos / BLOCK;
    sub = col_pos % BLOCK;
    if (tcol < tiles) begin
      run_sum = (sub == 0 ? 4'd0 : run_sum) + 4'(lvl);
      if (sub == BLOCK - 1) begin
        total = (row_phase == 0 ? 0 : partial_sums[tcol]) + run_sum;
        if (row_phase >= BLOCK - 1) begin
          avg = total / (BLOCK * BLOCK);
          if (avg > 3) avg = 3;
          t.glyph = glyph_reg[8*avg +: 8];
          t.tile_column = 9'(tcol);
          t.tile_row = tile_row_idx;
          t.row_end = (tcol + 1 == tiles);
          tiles_due.push_back(t);
        end else begin
          partial_sums[tcol] = 5'(total);
        end
      end
    end
    col_pos++;
    if (col_pos >= eff_w) begin
      col_pos = '0;
      row_phase++;
      if (row_phase >= BLOCK) begin
        row_phase = '0;
        tile_row_idx++;
      end
    end
  endtask

  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {px.red, px.green, px.blue};
    s_axis_tuser <= px.frame_start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    quantize_pixel(px);
  endtask

  function automatic pixel_t make_pixel(input logic [23:0] rgb, input logic fs);
    pixel_t px;
    px.red = rgb[23:16];
    px.green = rgb[15:8];
    px.blue = rgb[7:0];
    px.frame_start = fs;
    return px;
  endfunction

  // brightness band keeps tile averages spread over all four levels
  function automatic pixel_t random_pixel(input int band, input logic fs);
    int lo, hi;
    pixel_t px;
    lo = 0;
    hi = 255;
    if (band != 0 && $urandom_range(3) != 0) begin
      lo = 64 * (band - 1);
      hi = lo + 63;
    end
    px.blue = 8'($urandom_range(hi, lo));
    px.green = 8'($urandom_range(hi, lo));
    px.red = 8'($urandom_range(hi, lo));
    px.frame_start = fs;
    return px;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tiles_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_cycle(input logic wr, input logic sel, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic sel);
    logic [31:0] rd, want;
    apb_cycle(1'b0, sel, 32'h0, rd);
    want = (sel == pbaq_pkg::REG_IMAGE_WIDTH) ? {21'b0, width_reg} : glyph_reg;
    if (rd !== want) report_mismatch("register readback", rd, want);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    logic [31:0] unused;
    apb_cycle(1'b1, sel, value, unused);
    if (sel == pbaq_pkg::REG_IMAGE_WIDTH) width_reg = value[10:0];
    else glyph_reg = value;
    check_reg(sel);
  endtask

  task automatic test_reset_values();
    check_reg(pbaq_pkg::REG_IMAGE_WIDTH);
    check_reg(pbaq_pkg::REG_GLYPH_TABLE);
  endtask

  // each pixel sits on one side of a level threshold
  task automatic test_level_thresholds();
    logic [23:0] shades [9];
    shades = '{24'h000000, 24'h3F4040, 24'h404040, 24'h7F8080, 24'h808080,
               24'hBFC0C0, 24'hC0C0C0, 24'hFFFFFF, 24'hFFFFFE};
    write_reg(pbaq_pkg::REG_IMAGE_WIDTH, 32'd3);
    for (int i = 0; i < 9; i++) send_pixel(make_pixel(shades[i], i == 0));
    wait_drained();
  endtask

  task automatic test_narrow_widths();
    write_reg(pbaq_pkg::REG_GLYPH_TABLE, 32'h0000_0000);
    write_reg(pbaq_pkg::REG_GLYPH_TABLE, 32'hFFFF_FFFF);
    // zero width behaves as one pixel per row
    write_reg(pbaq_pkg::REG_IMAGE_WIDTH, 32'd0);
    send_pixel(random_pixel(0, 1'b1));
    send_pixel(random_pixel(0, 1'b0));
    wait_drained();
    write_reg(pbaq_pkg::REG_IMAGE_WIDTH, 32'd2);
    for (int i = 0; i < 4; i++) send_pixel(random_pixel(0, i == 0));
    wait_drained();
  endtask

  // shrink the width after four of the six pixels of the first pixel row
  task automatic test_width_change_mid_row();
    write_reg(pbaq_pkg::REG_GLYPH_TABLE, pbaq_pkg::GLYPH_TABLE_RST);
    write_reg(pbaq_pkg::REG_IMAGE_WIDTH, 32'd6);
    for (int i = 0; i < 4; i++) send_pixel(random_pixel(0, i == 0));
    wait_drained();
    write_reg(pbaq_pkg::REG_IMAGE_WIDTH, 32'd3);
    send_pixel(random_pixel(0, 1'b0));
    for (int i = 0; i < 6; i++) send_pixel(make_pixel(24'hFFFFFF, 1'b0));
    wait_drained();
  endtask

  task automatic test_random_frames(input int send_pct, input int recv_pct, input int count);
    int sent, w, rows, len, band;
    logic fresh, fs;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    wait_drained();
    write_reg(pbaq_pkg::REG_GLYPH_TABLE, $urandom());
    sent = 0;
    fresh = 1'b1;
    while (sent < count) begin
      if (fresh || $urandom_range(1) == 1) begin
        wait_drained();
        case ($urandom_range(9))
          0: w = $urandom_range(2);
          1: w = $urandom_range(64, 25);
          default: w = $urandom_range(24, 3);
        endcase
        write_reg(pbaq_pkg::REG_IMAGE_WIDTH, w);
        fresh = 1'b1;
      end
      rows = $urandom_range(9, 3);
      len = rows * ((w == 0) ? 1 : w);
      // broken frame, cut short anywhere
      if ($urandom_range(7) == 0) len = $urandom_range(len, 1);
      if (len > count - sent) len = count - sent;
      band = $urandom_range(4);
      for (int i = 0; i < len; i++) begin
        // a frame may also carry on from the previous one, or restart at random
        fs = ((i == 0) && (fresh || $urandom_range(7) != 0)) || ($urandom_range(99) == 0);
        send_pixel(random_pixel(band, fs));
      end
      sent += len;
      fresh = 1'b0;
    end
    wait_drained();
  endtask

  // output held off while pixels keep coming, so the input has to stall
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drained();
    write_reg(pbaq_pkg::REG_GLYPH_TABLE, $urandom());
    write_reg(pbaq_pkg::REG_IMAGE_WIDTH, 32'd6);
    hold_cycles = 300;
    for (int i = 0; i < 72; i++) send_pixel(random_pixel($urandom_range(4), i == 0));
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    tile_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tiles_due.size() == 0) begin
        report_mismatch("unexpected transaction", m_axis_tdata, 32'h0);
      end else begin
        want = tiles_due.pop_front();
        if (m_axis_tdata[7:0] !== want.glyph)
          report_mismatch("glyph", 32'(m_axis_tdata[7:0]), 32'(want.glyph));
        if (m_axis_tdata[16:8] !== want.tile_column)
          report_mismatch("tile_column", 32'(m_axis_tdata[16:8]), 32'(want.tile_column));
        if (m_axis_tdata[25:17] !== want.tile_row)
          report_mismatch("tile_row", 32'(m_axis_tdata[25:17]), 32'(want.tile_row));
        if (m_axis_tlast !== want.row_end)
          report_mismatch("row_end", 32'(m_axis_tlast), 32'(want.row_end));
      end
      tiles_seen++;
    end
  end

  // watchdog on cycles with no transaction on either stream
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_level_thresholds();
    test_narrow_widths();
    test_width_change_mid_row();
    test_random_frames(6, 84, 220);
    test_random_frames(84, 6, 220);
    test_random_frames(0, 0, 220);
    test_backpressure();
    wait_drained();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
